FILE: rtl/pfqm_pkg.sv
// Package with the shared widths, constants, codes and types of the pitch frame qualifier.
`timescale 1ns / 1ps
`default_nettype none

package pfqm_pkg;

    // Field widths.
    localparam int AMP_W   = 15;
    localparam int PITCH_W = 16;
    localparam int CFG_IW  = 2;

    // Reset values and constants.
    localparam logic [AMP_W-1:0]   AMP_MAX        = 15'h7FFF;
    localparam logic [AMP_W-1:0]   SILENCE_RESET  = 15'd200;
    localparam logic [PITCH_W-1:0] PITCH_LO_RESET = 16'd0;
    localparam logic [PITCH_W-1:0] PITCH_HI_RESET = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] REG_PITCH_LOW     = 2'd0;
    localparam logic [CFG_IW-1:0] REG_PITCH_HIGH    = 2'd1;
    localparam logic [CFG_IW-1:0] REG_SILENCE_LEVEL = 2'd2;

    // Insert command broadcast from the controller to every cell.
    typedef struct packed {
        logic               strobe;
        logic [PITCH_W-1:0] pitch;
    } pfqm_ins_t;

endpackage

`default_nettype wire

FILE: rtl/pfqm_cell.sv
// One cell of the sorted pitch history chain.
`timescale 1ns / 1ps
`default_nettype none

module pfqm_cell (
    input  wire logic                        clk,
    input  wire pfqm_pkg::pfqm_ins_t         ins,
    input  wire logic                        occupied,
    input  wire logic                        slot,
    input  wire logic [pfqm_pkg::PITCH_W-1:0] left_val,
    input  wire logic                        left_lt,
    output logic      [pfqm_pkg::PITCH_W-1:0] val,
    output logic                             lt
);
    import pfqm_pkg::*;

    logic [PITCH_W-1:0] val_reg;
    logic [PITCH_W-1:0] val_next;
    logic               take;

    // The new pitch sorts below this cell's value.
    assign lt = ins.pitch < val_reg;

    // An occupied cell above the new pitch shifts up; the first free cell fills.
    // The moving value is the left neighbor's if that one also sorts above the pitch.
    assign take     = ins.strobe && (occupied ? lt : slot);
    assign val_next = left_lt ? left_val : ins.pitch;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule

`default_nettype wire

FILE: rtl/pitch_frame_qualifier_median.sv
// Top level of the pitch frame qualifier: gating control and the sorted history chain.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-------------------------------
//  in      | input     | in_valid / in_stall   | amplitude, pitch
//  out     | output    | out_valid / out_stall | stable_valid, stable_pitch
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A frame passes through the accept beat, an evaluate cycle in which the pitch is
// inserted into the cell chain in sorted order, and an emit cycle that loads the output register.
// The next frame is accepted in the cycle after the emit cycle while the result beat may still wait.
// A stalled output holds the controller in its emit cycle until the register frees.
// Reset is asynchronous and active low; it clears all registers but the history cells, no clearing pass.
// cfg_ready is always high; indexes beyond the register list are ignored.
`timescale 1ns / 1ps
`default_nettype none

module pitch_frame_qualifier_median #(
    parameter int MEDIAN_SIZE = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [pfqm_pkg::AMP_W-1:0]    amplitude,
    input  wire logic [pfqm_pkg::PITCH_W-1:0]  pitch,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               stable_valid,
    output logic      [pfqm_pkg::PITCH_W-1:0]  stable_pitch,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pfqm_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [pfqm_pkg::PITCH_W-1:0]  cfg_data
);
    import pfqm_pkg::*;

    localparam int CNT_W = $clog2(MEDIAN_SIZE + 1);
    localparam int MID   = MEDIAN_SIZE / 2;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MEDIAN_SIZE - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_EMIT} st_t;

    st_t                state_reg;
    logic [PITCH_W-1:0] pitch_low_reg;
    logic [PITCH_W-1:0] pitch_high_reg;
    logic [AMP_W-1:0]   silence_reg;
    logic [AMP_W-1:0]   amp_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               reported_reg;
    logic               reported_next;
    logic [AMP_W-1:0]   min_reg;
    logic [AMP_W-1:0]   min_next;
    logic               report_reg;
    logic               report_next;
    logic               out_valid_reg;
    logic               stable_valid_reg;
    logic [PITCH_W-1:0] stable_pitch_reg;

    logic [AMP_W-1:0]   min_upd;
    logic               silent;
    logic               in_window;
    logic               onset;
    logic               store;
    pfqm_ins_t          ins;

    logic [PITCH_W-1:0] cell_val [MEDIAN_SIZE];
    logic               cell_lt  [MEDIAN_SIZE];

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);

    // Frame evaluation on the captured beat.
    always_comb
    begin
        silent    = (amp_reg <= silence_reg);
        in_window = (pitch_reg > pitch_low_reg) && (pitch_reg < pitch_high_reg);
        min_upd   = (amp_reg < min_reg) ? amp_reg : min_reg;
        onset     = ({1'b0, amp_reg, 1'b0} > ({2'b00, min_upd} + {1'b0, min_upd, 1'b0}));
        store     = !silent && !reported_reg && in_window;

        count_next    = count_reg;
        reported_next = reported_reg;
        min_next      = min_reg;
        report_next   = 1'b0;
        if (silent)
        begin
            count_next    = '0;
            reported_next = 1'b0;
            min_next      = AMP_MAX;
        end
        else if (reported_reg)
        begin
            min_next = min_upd;
            if (onset)
            begin
                count_next    = '0;
                reported_next = 1'b0;
                min_next      = AMP_MAX;
            end
        end
        else if (in_window)
        begin
            if (count_reg == CNT_LAST)
            begin
                count_next    = '0;
                reported_next = 1'b1;
                min_next      = AMP_MAX;
                report_next   = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    assign ins.strobe = (state_reg == ST_EVAL) && store;
    assign ins.pitch  = pitch_reg;

    // Sorted chain of history cells; each hands its value and compare to the right.
    for (genvar gi = 0; gi < MEDIAN_SIZE; gi++)
    begin : g_cell
        logic [PITCH_W-1:0] left_val;
        logic               left_lt;
        if (gi == 0)
        begin : g_first
            assign left_val = '0;
            assign left_lt  = 1'b0;
        end
        else
        begin : g_rest
            assign left_val = cell_val[gi-1];
            assign left_lt  = cell_lt[gi-1];
        end

        pfqm_cell u_cell (
            .clk      (clk),
            .ins      (ins),
            .occupied (CNT_W'(gi) < count_reg),
            .slot     (CNT_W'(gi) == count_reg),
            .left_val (left_val),
            .left_lt  (left_lt),
            .val      (cell_val[gi]),
            .lt       (cell_lt[gi])
        );
    end

    // Controller, configuration and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pitch_low_reg    <= PITCH_LO_RESET;
            pitch_high_reg   <= PITCH_HI_RESET;
            silence_reg      <= SILENCE_RESET;
            amp_reg          <= '0;
            pitch_reg        <= '0;
            count_reg        <= '0;
            reported_reg     <= 1'b0;
            min_reg          <= AMP_MAX;
            report_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            stable_valid_reg <= 1'b0;
            stable_pitch_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PITCH_LOW:     pitch_low_reg  <= cfg_data;
                    REG_PITCH_HIGH:    pitch_high_reg <= cfg_data;
                    REG_SILENCE_LEVEL: silence_reg    <= cfg_data[AMP_W-1:0];
                    default:           ;
                endcase
            end

            // The emit cycle reloads the register itself when the old beat leaves.
            if (out_valid_reg && !out_stall && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        amp_reg   <= amplitude;
                        pitch_reg <= pitch;
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    count_reg    <= count_next;
                    reported_reg <= reported_next;
                    min_reg      <= min_next;
                    report_reg   <= report_next;
                    state_reg    <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg    <= 1'b1;
                        stable_valid_reg <= report_reg;
                        stable_pitch_reg <= report_reg ? cell_val[MID] : '0;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign stable_valid = stable_valid_reg;
    assign stable_pitch = stable_pitch_reg;

`ifndef SYNTH
    // The fill count never reaches the full size; a full history reports at once.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(MEDIAN_SIZE))
        else $error("history count out of range");

    // After a report no pitch is held until re-arm.
    a_reported_empty: assert property (@(posedge clk) disable iff (!rst_n)
        reported_reg |-> (count_reg == '0))
        else $error("history not empty while reported");

    // A result without a report carries zero pitch.
    a_zero_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !stable_valid) |-> (stable_pitch == '0))
        else $error("pitch not zero without report");

    // A report follows only from an evaluate cycle that filled the history.
    a_report_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(report_reg) |-> ($past(state_reg) == ST_EVAL && reported_reg))
        else $error("report without filled history");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the pitch frame qualifier: random and directed frames.
`timescale 1ns / 1ps

module tb_top;
    import pfqm_pkg::*;

    localparam int HIST_DEPTH    = 5;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_PAD     = 12;
    localparam int STALL_LIMIT   = 3000;
    // Index past the register list; writes to it must be ignored.
    localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [AMP_W-1:0]   amp;
        logic [PITCH_W-1:0] pit;
    } frame_t;

    typedef struct packed {
        logic               hit;
        logic [PITCH_W-1:0] median;
    } median_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [AMP_W-1:0] amplitude = '0;
    logic [PITCH_W-1:0] pitch = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic stable_valid;
    logic [PITCH_W-1:0] stable_pitch;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [PITCH_W-1:0] cfg_data = '0;

    // Frames waiting to be sent and medians waiting to be seen.
    frame_t  frame_q[$];
    median_t median_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int err_count = 0;
    int frames_queued = 0;
    int idle_cycles = 0;

    // Predictor state and its copy of the registers.
    logic [PITCH_W-1:0] hist [HIST_DEPTH];
    int                 hist_cnt;
    logic               note_held;
    logic [AMP_W-1:0]   min_amp;
    logic [PITCH_W-1:0] cfg_lo = PITCH_LO_RESET;
    logic [PITCH_W-1:0] cfg_hi = PITCH_HI_RESET;
    logic [AMP_W-1:0]   cfg_sil = SILENCE_RESET;

    pitch_frame_qualifier_median uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .amplitude(amplitude),
        .pitch(pitch),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .stable_valid(stable_valid),
        .stable_pitch(stable_pitch),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Forget the current note: empty history, no report held, minimum at full scale.
    function automatic void clear_note();
        hist_cnt  = 0;
        note_held = 1'b0;
        min_amp   = AMP_MAX;
    endfunction

    // Works out the result of one frame and advances the predictor state.
    function automatic median_t qualify_frame(input frame_t f);
        median_t r;
        logic [PITCH_W-1:0] srt [HIST_DEPTH];
        logic [PITCH_W-1:0] t;
        r = '0;
        if (f.amp <= cfg_sil)
        begin
            clear_note();
            return r;
        end
        // After a report, follow the decay and re-arm on a fresh onset.
        if (note_held)
        begin
            if (f.amp < min_amp)
                min_amp = f.amp;
            if (2 * int'(f.amp) > 3 * int'(min_amp))
                clear_note();
            return r;
        end
        if (f.pit > cfg_lo && f.pit < cfg_hi)
        begin
            hist[hist_cnt] = f.pit;
            hist_cnt++;
            if (hist_cnt == HIST_DEPTH)
            begin
                srt = hist;
                for (int i = 0; i < HIST_DEPTH - 1; i++)
                    for (int j = 0; j < HIST_DEPTH - 1 - i; j++)
                        if (srt[j] > srt[j+1])
                        begin
                            t = srt[j];
                            srt[j] = srt[j+1];
                            srt[j+1] = t;
                        end
                r.hit    = 1'b1;
                r.median = srt[HIST_DEPTH/2];
                clear_note();
                note_held = 1'b1;
            end
        end
        return r;
    endfunction

    // Driver: predicts each accepted beat and loads the next pending frame.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            amplitude <= '0;
            pitch     <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                median_q.push_back(qualify_frame('{amp: amplitude, pit: pitch}));
            if (!in_valid || !in_stall)
            begin
                if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid  <= 1'b1;
                    amplitude <= frame_q[0].amp;
                    pitch     <= frame_q[0].pit;
                    void'(frame_q.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, or a long hold-off when one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Monitor: compares each result beat with the oldest expected median.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (median_q.size() == 0)
            begin
                err_count++;
                $display("%0t: result beat with nothing expected: valid %0b pitch %0d",
                         $time, stable_valid, stable_pitch);
            end
            else
            begin
                if (stable_valid !== median_q[0].hit || stable_pitch !== median_q[0].median)
                begin
                    err_count++;
                    $display("%0t: mismatch: expected valid %0b pitch %0d, %s",
                             $time, median_q[0].hit, median_q[0].median,
                             $sformatf("got valid %0b pitch %0d",
                                       stable_valid, stable_pitch));
                end
                void'(median_q.pop_front());
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [PITCH_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PITCH_LOW:     cfg_lo = val;
            REG_PITCH_HIGH:    cfg_hi = val;
            REG_SILENCE_LEVEL: cfg_sil = val[AMP_W-1:0];
            default:           ;
        endcase
        @(negedge clk);
    endtask

    task automatic push_frame(input int amp, input int pit);
        frame_q.push_back('{amp: amp[AMP_W-1:0], pit: pit[PITCH_W-1:0]});
        frames_queued++;
    endtask

    // Waits until every frame is sent and every median has come back.
    task automatic drain();
        do
            @(negedge clk);
        while (frame_q.size() != 0 || in_valid || median_q.size() != 0);
        repeat (DRAIN_PAD) @(negedge clk);
    endtask

    function automatic int loud_amp();
        if (cfg_sil == AMP_MAX)
            return int'(AMP_MAX);
        return $urandom_range(int'(AMP_MAX), int'(cfg_sil) + 1);
    endfunction

    // One plucked note: steady pitch with jitter and stray readings, decaying amplitude.
    task automatic push_note();
        int center;
        int jit;
        int n;
        int a;
        int p;
        if (int'(cfg_hi) - int'(cfg_lo) > 1)
            center = $urandom_range(int'(cfg_hi) - 1, int'(cfg_lo) + 1);
        else
            center = $urandom_range(65535, 0);
        jit = $urandom_range(64, 0);
        n = $urandom_range(16, 4);
        a = loud_amp();
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(9) == 0)
                p = $urandom_range(65535, 0);
            else
            begin
                p = center + $urandom_range(2 * jit, 0) - jit;
                if (p < 0)
                    p = 0;
                if (p > 65535)
                    p = 65535;
            end
            push_frame(a, p);
            // Next amplitude: mostly decay, sometimes near the onset threshold or a new pluck.
            case ($urandom_range(11))
                0:       a = (a * 3) / 2 + $urandom_range(1, 0);
                1:       a = loud_amp();
                default: a = (a * $urandom_range(99, 75)) / 100;
            endcase
            if (a > int'(AMP_MAX))
                a = int'(AMP_MAX);
            if (a <= int'(cfg_sil) && cfg_sil != AMP_MAX)
                a = int'(cfg_sil) + 1;
        end
        if ($urandom_range(1))
            push_frame($urandom_range(int'(cfg_sil), 0), $urandom_range(65535, 0));
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = frames_queued + count;
        while (frames_queued < stop_at)
        begin
            if ($urandom_range(9) < 8)
                push_note();
            else
                repeat ($urandom_range(4, 1))
                    push_frame($urandom_range(int'(AMP_MAX), 0), $urandom_range(65535, 0));
        end
    endtask

    initial
    begin
        for (int i = 0; i < HIST_DEPTH; i++)
            hist[i] = '0;
        clear_note();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 48;

        // Directed frames under reset settings: silence bound, window edges, report and re-arm.
        push_frame(0, 16'h5555);
        push_frame(200, 16'hAAAA);
        push_frame(201, 0);
        push_frame(201, 65535);
        push_frame(32767, 65534);
        push_frame(15'h5555, 1);
        push_frame(15'h2AAA, 30000);
        push_frame(200, 30000);
        push_frame(32767, 65534);
        push_frame(32767, 1);
        push_frame(32767, 30000);
        push_frame(32767, 30000);
        push_frame(32767, 2);
        push_frame(32767, 65535);
        push_frame(1000, 5);
        push_frame(1500, 5);
        push_frame(1501, 16'hAAAA);
        repeat (5) push_frame(300, 16'h5555);
        push_frame(201, 7);
        push_frame(200, 7);
        drain();

        // Guitar-like window; a long receiver hold-off fills the block mid-phase.
        write_reg(REG_PITCH_LOW, 16'd1600);
        write_reg(REG_PITCH_HIGH, 16'd16000);
        write_reg(REG_SILENCE_LEVEL, 16'd200);
        run_random(600);
        while (frame_q.size() > 300)
            @(negedge clk);
        hold_req = hold_req + 1;
        drain();

        // Full window, only zero amplitude is silent.
        send_idle_pct = 48;
        recv_idle_pct = 18;
        write_reg(REG_PITCH_LOW, 16'd0);
        write_reg(REG_PITCH_HIGH, 16'hFFFF);
        write_reg(REG_SILENCE_LEVEL, 16'd0);
        run_random(600);
        drain();

        // Everything silent: the level is masked to full scale. The unused index changes nothing.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_SILENCE_LEVEL, 16'hFFFF);
        write_reg(REG_UNUSED, 16'h0001);
        run_random(30);
        drain();

        // Empty window: no pitch is ever stored.
        write_reg(REG_SILENCE_LEVEL, 16'd100);
        write_reg(REG_PITCH_LOW, 16'hFFFF);
        write_reg(REG_PITCH_HIGH, 16'd0);
        run_random(30);
        drain();

        // Wide window with a higher noise floor, no idling on either side.
        write_reg(REG_PITCH_LOW, 16'd100);
        write_reg(REG_PITCH_HIGH, 16'd60000);
        write_reg(REG_SILENCE_LEVEL, 16'd500);
        run_random(600);
        drain();

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
